// ===== design/bba_pkg.sv =====
// Shared types and constants for the block bitmap allocator.
package bba_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int ADDR_W     = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = 11;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_FIND  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_BLOCK = 2'd1,
        STAT_NO_RUN    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUERY,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// ===== design/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/block_bitmap_allocator_top.sv =====
// Block bitmap allocator: one used bit per disk block, with allocate, free, query and run search.
//
// Input words arrive on the s_axis channel: tuser carries the opcode, tdata the block
// index and the run length. Each input word gives exactly one result word on m_axis:
// tuser carries the status, tdata the free flag and the start of a found run.
// Write the block count through i_cfg_we / i_cfg_data while the block is idle; it is unchecked.
//
// The block takes one word at a time. Allocate, free and a bad index go from acceptance
// to the result stage and then to the output register; a query reads the bitmap first. A run
// search reads the bitmap RAM one bit per cycle, until a run is found or the block count ends.
// The single read port of the bitmap RAM sets that pace.
//
// After reset every entry of the bitmap RAM is cleared, one entry per cycle;
// s_axis_tready stays low during that pass, while configuration writes are taken.
// The result sits in an output register, so the next word is accepted while a result
// still waits. If the receiver stalls and the next result is ready too, that result
// is held until the output register empties.
module block_bitmap_allocator_top
    import bba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [23:0]      s_axis_tdata,   // block_index[9:0], run_length[20:10], zeros
    input  logic [1:0]       s_axis_tuser,   // opcode[1:0]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // block_is_free[0], run_start[10:1], zeros
    output logic [1:0]       m_axis_tuser    // status[1:0]
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_blocks;
    logic [ADDR_W-1:0]  r_clr, n_clr;
    logic [ADDR_W-1:0]  r_ptr, n_ptr;
    logic [CNT_W-1:0]   r_run, n_run;
    logic [CNT_W-1:0]   r_len, n_len;
    t_status            r_res_status, n_res_status;
    logic               r_res_free, n_res_free;
    logic [ADDR_W-1:0]  r_res_start, n_res_start;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic               r_out_free, n_out_free;
    logic [ADDR_W-1:0]  r_out_start, n_out_start;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [0:0]         ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [0:0]         ram_rdata;

    logic [CNT_W-1:0]   w_cnt;
    logic [ADDR_W-1:0]  in_idx;
    logic [CNT_W-1:0]   in_len;
    t_op                in_op;
    logic               in_bad;
    logic               out_room;
    logic [CNT_W-1:0]   run_nx;
    logic [CNT_W-1:0]   ptr_nx;

    bba_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Effective block count saturates at the bitmap size.
    assign w_cnt    = (r_blocks > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : r_blocks;
    assign in_idx   = s_axis_tdata[ADDR_W-1:0];
    assign in_len   = s_axis_tdata[ADDR_W+CNT_W-1:ADDR_W];
    assign in_op    = t_op'(s_axis_tuser);
    assign in_bad   = {1'b0, in_idx} >= w_cnt;
    assign out_room = !r_out_valid || m_axis_tready;
    assign run_nx   = ram_rdata[0] ? '0 : r_run + CNT_W'(1);
    assign ptr_nx   = {1'b0, r_ptr} + CNT_W'(1);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_ptr        = r_ptr;
        n_run        = r_run;
        n_len        = r_len;
        n_res_status = r_res_status;
        n_res_free   = r_res_free;
        n_res_start  = r_res_start;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_free   = r_out_free;
        n_out_start  = r_out_start;
        ram_we       = 1'b0;
        ram_waddr    = r_clr;
        ram_wdata    = 1'b0;
        ram_raddr    = in_idx;
        s_axis_tready = 1'b0;

        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_clr  = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(MAX_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_len        = in_len;
                    n_res_status = STAT_OK;
                    n_res_free   = 1'b0;
                    n_res_start  = '0;
                    n_state      = S_DONE;
                    if (in_bad) begin
                        n_res_status = STAT_BAD_BLOCK;
                    end else begin
                        case (in_op)
                            OP_ALLOC, OP_FREE: begin
                                ram_we    = 1'b1;
                                ram_waddr = in_idx;
                                ram_wdata = (in_op == OP_ALLOC);
                            end
                            OP_QUERY: begin
                                n_state = S_QUERY;
                            end
                            OP_FIND: begin
                                if (in_len == '0) begin
                                    n_res_start = in_idx;
                                end else begin
                                    n_ptr   = in_idx;
                                    n_run   = '0;
                                    n_state = S_SCAN;
                                end
                            end
                            default: begin
                                n_state = S_DONE;
                            end
                        endcase
                    end
                end
            end
            S_QUERY: begin
                n_res_free = !ram_rdata[0];
                n_state    = S_DONE;
            end
            S_SCAN: begin
                // Read data belongs to r_ptr; the next address is fetched meanwhile.
                ram_raddr = ptr_nx[ADDR_W-1:0];
                n_run     = run_nx;
                if (run_nx >= r_len) begin
                    n_res_start = ADDR_W'(ptr_nx - r_len);
                    n_state     = S_DONE;
                end else if (ptr_nx >= w_cnt) begin
                    n_res_status = STAT_NO_RUN;
                    n_state      = S_DONE;
                end else begin
                    n_ptr = ptr_nx[ADDR_W-1:0];
                end
            end
            S_DONE: begin
                if (out_room) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_free   = r_res_free;
                    n_out_start  = r_res_start;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_blocks    <= CNT_W'(1024);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_blocks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_run        <= n_run;
        r_len        <= n_len;
        r_res_status <= n_res_status;
        r_res_free   <= n_res_free;
        r_res_start  <= n_res_start;
        r_out_status <= n_out_status;
        r_out_free   <= n_out_free;
        r_out_start  <= n_out_start;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {5'b0, r_out_start, r_out_free};

    // Only one word is in flight, so acceptance is never back to back.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // The scan pointer never walks past the block count.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({1'b0, r_ptr} < w_cnt))
        else $error("scan pointer beyond block count");

    // A result that is not ok carries no free flag and no run start.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != STAT_OK)) |-> (m_axis_tdata == '0))
        else $error("failed result carries payload");

    // A new result is loaded only from the result stage.
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && n_out_valid) |-> (r_state == S_DONE))
        else $error("output loaded outside result stage");

endmodule
